>>> rtl/sil_pkg.sv
package sil_pkg;

  // Clamp bounds for the mesh size.
  localparam int unsigned MAX_SEGMENTS = 256;
  localparam int unsigned MAX_RINGS    = 255;

  // Configuration register indexes.
  localparam logic REG_RING_SIZE  = 1'b0;
  localparam logic REG_RING_COUNT = 1'b1;

  // Final corner of a cap triangle and of a band quad (two triangles).
  localparam logic [2:0] CORNER_TRI_LAST  = 3'd2;
  localparam logic [2:0] CORNER_BAND_LAST = 3'd5;

  // Corner codes inside a band quad.
  localparam logic [2:0] CORNER_0 = 3'd0;
  localparam logic [2:0] CORNER_1 = 3'd1;
  localparam logic [2:0] CORNER_3 = 3'd3;
  localparam logic [2:0] CORNER_4 = 3'd4;

  localparam logic [8:0] RING_SIZE_RESET  = 9'd8;
  localparam logic [7:0] RING_COUNT_RESET = 8'd8;

  typedef enum logic [1:0] {
    SEC_BOTTOM = 2'd0,
    SEC_BANDS  = 2'd1,
    SEC_TOP    = 2'd2
  } section_t;

  // Clamped mesh geometry and the products derived from it.
  typedef struct packed {
    logic [8:0]  seg_n;     // segments per ring, 1..256
    logic [7:0]  ring_n;    // rings, 1..255
    logic [15:0] pole_lo;   // seg_n * ring_n, the south pole vertex
    logic [15:0] top_base;  // seg_n * (ring_n - 1), first vertex of the top ring
  } geom_t;

  // Segment residue produced by the reduction unit.
  typedef struct packed {
    logic       load;
    logic [7:0] value;
  } modload_t;

  // One entry of the index list.
  typedef struct packed {
    logic        last;
    logic [18:0] list_position;
    logic [15:0] vertex_index;
  } idx_t;

  // (xm + k) mod s for xm < s and k <= 2.
  function automatic logic [7:0] mod_add(input logic [7:0] xm, input logic [1:0] k,
                                         input logic [8:0] s);
    logic [9:0] t;
    t = {2'b00, xm} + {8'd0, k};
    if (t >= {1'b0, s}) begin
      t = t - {1'b0, s};
    end
    if (t >= {1'b0, s}) begin
      t = t - {1'b0, s};
    end
    return t[7:0];
  endfunction

endpackage

>>> rtl/sil_mod_unit.sv
module sil_mod_unit
  import sil_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [8:0] seg_n,
  input  logic [7:0] seg_cnt,
  output logic       busy,
  output modload_t   modload
);

  // Restoring remainder of seg_cnt / seg_n, one dividend bit per cycle.
  logic       busy_r, busy_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [8:0] rem_shift;
  logic [8:0] rem_red;

  always_comb begin
    rem_shift = {rem_r, seg_cnt[bit_r]};
    rem_red   = (rem_shift >= seg_n) ? (rem_shift - seg_n) : rem_shift;
  end

  always_comb begin
    busy_nxt = busy_r;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = 3'd7;
      rem_nxt  = 8'd0;
    end else if (busy_r) begin
      rem_nxt = rem_red[7:0];
      bit_nxt = bit_r - 3'd1;
      if (bit_r == 3'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      bit_r  <= 3'd7;
      rem_r  <= 8'd0;
    end else begin
      busy_r <= busy_nxt;
      bit_r  <= bit_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign busy          = busy_r;
  assign modload.load  = busy_r && !start && (bit_r == 3'd0);
  assign modload.value = rem_red[7:0];

endmodule

>>> rtl/sil_walker.sv
module sil_walker
  import sil_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       restart,
  input  geom_t      geom,
  input  modload_t   modload,
  output logic [7:0] seg_cnt,
  output idx_t       idx
);

  section_t    sec_r, sec_nxt, sec_e;
  logic [7:0]  seg_r, seg_nxt, seg_e;
  logic [7:0]  segmod_r, segmod_nxt, segmod_e;
  logic [7:0]  ring_r, ring_nxt, ring_e;
  logic [2:0]  corner_r, corner_nxt, corner_e;
  logic [15:0] row_r, row_nxt, row_e;
  logic [18:0] pos_r, pos_nxt, pos_e;

  logic        odd;
  logic        seg_end;
  logic        tri_end;
  logic [7:0]  m_x, m_x1, m_xo, m_x1o;
  logic [15:0] vtx;
  logic        last;
  logic [8:0]  ring_inc;
  logic [17:0] row_prod;

  // A restart clears the counters before this index is formed.
  always_comb begin
    sec_e    = restart ? SEC_BOTTOM : sec_r;
    seg_e    = restart ? 8'd0 : seg_r;
    segmod_e = restart ? 8'd0 : segmod_r;
    ring_e   = restart ? 8'd0 : ring_r;
    corner_e = restart ? 3'd0 : corner_r;
    row_e    = restart ? 16'd0 : row_r;
    pos_e    = restart ? 19'd0 : pos_r;
  end

  always_comb begin
    odd     = ring_e[0];
    seg_end = ({1'b0, seg_e} + 9'd1) >= geom.seg_n;
    m_x     = segmod_e;
    m_x1    = mod_add(segmod_e, 2'd1, geom.seg_n);
    m_xo    = mod_add(segmod_e, {1'b0, odd}, geom.seg_n);
    m_x1o   = mod_add(segmod_e, 2'd1 + {1'b0, odd}, geom.seg_n);
    last    = 1'b0;
    case (sec_e)
      SEC_BOTTOM: begin
        if (corner_e == CORNER_0) begin
          vtx = geom.pole_lo;
        end else if (corner_e == CORNER_1) begin
          vtx = {8'd0, m_x};
        end else begin
          vtx = {8'd0, m_x1};
        end
      end
      SEC_BANDS: begin
        case (corner_e)
          CORNER_0: vtx = row_e + {8'd0, m_x};
          CORNER_1, CORNER_3: vtx = row_e + {7'd0, geom.seg_n} + {8'd0, m_xo};
          CORNER_4: vtx = row_e + {7'd0, geom.seg_n} + {8'd0, m_x1o};
          default: vtx = row_e + {8'd0, m_x1};
        endcase
      end
      default: begin
        // Top cap; the unused section code behaves the same way.
        if (corner_e == CORNER_0) begin
          vtx = geom.pole_lo + 16'd1;
        end else if (corner_e == CORNER_1) begin
          vtx = geom.top_base + {8'd0, m_x1};
        end else begin
          vtx = geom.top_base + {8'd0, m_x};
        end
        last = seg_end && (corner_e >= CORNER_TRI_LAST);
      end
    endcase
  end

  assign idx.vertex_index  = vtx;
  assign idx.list_position = pos_e;
  assign idx.last          = last;

  always_comb begin
    ring_inc = {1'b0, ring_e} + 9'd1;
    row_prod = ring_inc * geom.seg_n;
    tri_end  = (sec_e == SEC_BANDS) ? (corner_e >= CORNER_BAND_LAST)
                                    : (corner_e >= CORNER_TRI_LAST);
    sec_nxt    = sec_e;
    seg_nxt    = seg_e;
    segmod_nxt = segmod_e;
    ring_nxt   = ring_e;
    corner_nxt = corner_e + 3'd1;
    row_nxt    = row_e;
    pos_nxt    = pos_e + 19'd1;
    if (tri_end) begin
      corner_nxt = 3'd0;
      if (seg_end) begin
        seg_nxt    = 8'd0;
        segmod_nxt = 8'd0;
        case (sec_e)
          SEC_BOTTOM: begin
            ring_nxt = 8'd0;
            row_nxt  = 16'd0;
            sec_nxt  = (geom.ring_n >= 8'd2) ? SEC_BANDS : SEC_TOP;
          end
          SEC_BANDS: begin
            if (({1'b0, ring_e} + 9'd2) >= {1'b0, geom.ring_n}) begin
              sec_nxt = SEC_TOP;
            end else begin
              ring_nxt = ring_inc[7:0];
              row_nxt  = row_prod[15:0];
            end
          end
          default: begin
            // End of the list: wrap to the start.
            sec_nxt  = SEC_BOTTOM;
            ring_nxt = 8'd0;
            row_nxt  = 16'd0;
            pos_nxt  = 19'd0;
          end
        endcase
      end else begin
        // Here seg_e + 1 < seg_n, so the residue equals the count.
        seg_nxt    = seg_e + 8'd1;
        segmod_nxt = segmod_e + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r    <= SEC_BOTTOM;
      seg_r    <= 8'd0;
      segmod_r <= 8'd0;
      ring_r   <= 8'd0;
      corner_r <= 3'd0;
      row_r    <= 16'd0;
      pos_r    <= 19'd0;
    end else if (accept) begin
      sec_r    <= sec_nxt;
      seg_r    <= seg_nxt;
      segmod_r <= segmod_nxt;
      ring_r   <= ring_nxt;
      corner_r <= corner_nxt;
      row_r    <= row_nxt;
      pos_r    <= pos_nxt;
    end else if (modload.load) begin
      segmod_r <= modload.value;
    end
  end

  assign seg_cnt = seg_r;

endmodule

>>> rtl/sphere_index_list_generator.sv
// A result appears in the output register in the cycle after its input transfer.
// Throughput: one index per cycle while out_tready stays high and no reduction pass is
// running; the walker forms the index combinationally and steps its counters on a transfer.
// After reset and after every configuration write in_tready stays low while a bit-serial
// unit reduces the segment counter modulo the new ring size.
// Reset (rst_n low, synchronous) restores ring_size 8, ring_count 8 and clears the list.
module sphere_index_list_generator
  import sil_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, [7:1] zero
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] vertex_index, [34:16] list_position, [39:35] zero
  output logic        out_tlast,  // last index of the list
  // Configuration port.
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [8:0]  cfg_wdata
);

  logic [8:0]  ring_size_r;
  logic [7:0]  ring_count_r;
  logic [8:0]  seg_n;
  logic [7:0]  ring_n;
  logic [15:0] pole_lo_r, pole_lo_nxt;
  logic [15:0] top_base_r, top_base_nxt;
  geom_t       geom;

  logic        mod_busy;
  modload_t    modload;
  logic [7:0]  seg_cnt;
  idx_t        idx;
  logic        in_xfer;

  idx_t        out_r;
  logic        out_valid_r, out_valid_nxt;

  // Configuration registers; a write to an index takes effect at the next edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r  <= RING_SIZE_RESET;
      ring_count_r <= RING_COUNT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_RING_SIZE:  ring_size_r  <= cfg_wdata;
        REG_RING_COUNT: ring_count_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Sizes outside the legal range are clamped to it.
  always_comb begin
    if (ring_size_r == 9'd0) begin
      seg_n = 9'd1;
    end else if (ring_size_r > 9'(MAX_SEGMENTS)) begin
      seg_n = 9'(MAX_SEGMENTS);
    end else begin
      seg_n = ring_size_r;
    end
    if (ring_count_r == 8'd0) begin
      ring_n = 8'd1;
    end else if (ring_count_r > 8'(MAX_RINGS)) begin
      ring_n = 8'(MAX_RINGS);
    end else begin
      ring_n = ring_count_r;
    end
  end

  // The pole and top-ring products are registered. They settle well inside the
  // reduction window, during which no transfer is taken.
  always_comb begin
    pole_lo_nxt  = 16'(seg_n * ring_n);
    top_base_nxt = 16'(seg_n * (ring_n - 8'd1));
  end

  always_ff @(posedge clk) begin
    pole_lo_r  <= pole_lo_nxt;
    top_base_r <= top_base_nxt;
  end

  assign geom.seg_n    = seg_n;
  assign geom.ring_n   = ring_n;
  assign geom.pole_lo  = pole_lo_r;
  assign geom.top_base = top_base_r;

  // The reduction unit keeps the segment residue exact when the ring size
  // changes under a list that is part way through.
  sil_mod_unit u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_wr_en),
    .seg_n   (seg_n),
    .seg_cnt (seg_cnt),
    .busy    (mod_busy),
    .modload (modload)
  );

  // A transfer is taken when no reduction or configuration write is under way and the
  // output register is empty or is being emptied in the same cycle.
  assign in_tready = !mod_busy && !cfg_wr_en && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  sil_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_xfer),
    .restart (in_tdata[0]),
    .geom    (geom),
    .modload (modload),
    .seg_cnt (seg_cnt),
    .idx     (idx)
  );

  // Output register.
  assign out_valid_nxt = in_xfer || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_r <= idx;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.list_position, out_r.vertex_index};
  assign out_tlast  = out_r.last;

  // No input transfer while the residue is being recomputed.
  assert property (@(posedge clk) disable iff (!rst_n) mod_busy |-> !in_tready)
    else $error("input taken during residue reduction");

  // A restart always yields list position zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tdata[0]) |=> (out_tvalid && out_tdata[34:16] == 19'd0))
    else $error("restart did not begin the list at position zero");

  // Every input transfer leaves a result in the output register.
  assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> out_tvalid)
    else $error("result lost after input transfer");

  // Reset starts the reduction window, so nothing is taken straight after it.
  assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready directly after reset");

endmodule

>>> test/sphere_index_list_generator_tb.sv
`timescale 1ns / 1ps

module sphere_index_list_generator_tb;
  import sil_pkg::*;

  // Cycles without any transfer on either channel before the run is declared hung.
  // The longest deliberate hold-off is HOLD_CYCLES; a register write and its reduction pass add to it.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES = 14;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned MAX_PRINTED = 40;

  // Mirrors the index walker: it keeps its own copy of the geometry registers and counters,
  // and it holds the indices that are still owed by the block, oldest first.
  class index_list_scoreboard;
    logic [8:0]  ring_size_q;
    logic [7:0]  ring_count_q;
    section_t    sec;
    logic [7:0]  seg;
    logic [7:0]  ring;
    logic [2:0]  corner;
    logic [15:0] row_base;
    logic [18:0] pos;
    idx_t        owed_indices[$];
    int unsigned mismatches;

    function new();
      ring_size_q  = RING_SIZE_RESET;
      ring_count_q = RING_COUNT_RESET;
      mismatches   = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      sec      = SEC_BOTTOM;
      seg      = '0;
      ring     = '0;
      corner   = '0;
      row_base = '0;
      pos      = '0;
    endfunction

    function void write_reg(logic idx, logic [8:0] value);
      if (idx == REG_RING_SIZE) begin
        ring_size_q = value;
      end else begin
        ring_count_q = value[7:0];
      end
    endfunction

    // Forms the index at the current list position and then advances the walk.
    function idx_t walk_index(bit restart);
      int unsigned s, r, x, c, v, o, top_base;
      bit          seg_end;
      idx_t        e;
      s = ring_size_q;
      if (s < 1) s = 1;
      if (s > MAX_SEGMENTS) s = MAX_SEGMENTS;
      r = ring_count_q;
      if (r < 1) r = 1;
      if (r > MAX_RINGS) r = MAX_RINGS;
      if (restart) clear_walk();
      x        = seg;
      c        = corner;
      seg_end  = (x + 1 >= s);
      top_base = s * (r - 1);
      e.last   = 1'b0;
      case (sec)
        SEC_BOTTOM: begin
          if (c == CORNER_0) v = s * r;
          else if (c == CORNER_1) v = x % s;
          else v = (x + 1) % s;
        end
        SEC_BANDS: begin
          // Odd rows are staggered by one segment on the upper ring.
          o = ring[0];
          case (c)
            CORNER_0:           v = row_base + x % s;
            CORNER_1, CORNER_3: v = row_base + s + (x + o) % s;
            CORNER_4:           v = row_base + s + (x + 1 + o) % s;
            default:            v = row_base + (x + 1) % s;
          endcase
        end
        default: begin
          if (c == CORNER_0) v = s * r + 1;
          else if (c == CORNER_1) v = top_base + (x + 1) % s;
          else v = top_base + x % s;
          e.last = seg_end && (c >= CORNER_TRI_LAST);
        end
      endcase
      e.vertex_index  = 16'(v);
      e.list_position = pos;

      pos = pos + 1'b1;
      if ((sec == SEC_BANDS) ? (c >= CORNER_BAND_LAST) : (c >= CORNER_TRI_LAST)) begin
        corner = '0;
        if (seg_end) begin
          seg = '0;
          if (sec == SEC_BOTTOM) begin
            ring     = '0;
            row_base = '0;
            sec      = (r >= 2) ? SEC_BANDS : SEC_TOP;
          end else if (sec == SEC_BANDS) begin
            if (ring + 2 >= r) begin
              sec = SEC_TOP;
            end else begin
              ring     = ring + 1'b1;
              row_base = 16'(ring * s);
            end
          end else begin
            clear_walk();
          end
        end else begin
          seg = 8'(x + 1);
        end
      end else begin
        corner = corner + 1'b1;
      end
      return e;
    endfunction

    function void note_request(bit restart);
      owed_indices.push_back(walk_index(restart));
    endfunction

    function int unsigned pending();
      return owed_indices.size();
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_index(idx_t got);
      idx_t want;
      if (owed_indices.size() == 0) begin
        report($sformatf("index %0d at position %0d with none owed",
                         got.vertex_index, got.list_position));
      end else begin
        want = owed_indices.pop_front();
        if (got.vertex_index !== want.vertex_index)
          report($sformatf("position %0d: vertex_index %0d, expected %0d",
                           want.list_position, got.vertex_index, want.vertex_index));
        if (got.list_position !== want.list_position)
          report($sformatf("list_position %0d, expected %0d",
                           got.list_position, want.list_position));
        if (got.last !== want.last)
          report($sformatf("position %0d: last %b, expected %b",
                           want.list_position, got.last, want.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [0] restart, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [15:0] vertex_index, [34:16] list_position, [39:35] zero
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [8:0]  cfg_wdata = '0;

  index_list_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  sphere_index_list_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Receiver side. A hold-off request from the stimulus keeps out_tready low for a long
  // stretch so that the output register fills and the block has to stall its input;
  // otherwise out_tready is dropped at random at the rate set for the current phase.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_req   = 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Both channels are sampled on the rising edge, before any of the edge's updates land.
  // The input transfer is noted first, so that an index leaving in the same cycle is still
  // matched against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata[0]);
      if (out_tvalid && out_tready)
        sb.check_index('{last: out_tlast, list_position: out_tdata[34:16],
                         vertex_index: out_tdata[15:0]});
    end
  end

  // Watchdog: the run is hung once neither channel has made a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request, idling beforehand at the sender rate of the phase, and returns on
  // the edge at which it is taken. in_tvalid is left high so that back-to-back requests
  // need no gap.
  task automatic send_request(bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
  endtask

  // Registers are only written with the walker idle: the task first waits so that
  // the last request taken has been noted, then every owed index must have come out, and
  // any reduction pass started by an earlier write must have finished (in_tready high again).
  task automatic write_reg(logic idx, logic [8:0] value);
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    while (!in_tready) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned pick;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. First a few requests at the reset geometry, with a restart part way.
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);

    // A size of zero clamps to one segment, and the ring count register keeps only its
    // low eight bits, so this is a single-ring sphere with a six-entry list. The walk runs
    // past the end of the list to see it wrap.
    write_reg(REG_RING_SIZE, 9'd0);
    write_reg(REG_RING_COUNT, 9'h100);
    send_request(1'b1);
    repeat (7) send_request(1'b0);

    // Stop at the head of the top cap, then grow the sphere to its largest size without a
    // restart: the stale counters meet the new bounds, giving the highest vertex numbers.
    // The segment count is written above its range and clamps to the maximum.
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    write_reg(REG_RING_SIZE, 9'h1FF);
    write_reg(REG_RING_COUNT, 9'd255);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);

    // Random part. Phases rotate through the idling patterns: none, sender only, receiver
    // only and both together. Most geometries are small, so that whole lists go by and the
    // final-index flag is seen often; some are drawn over the full register range. A phase
    // does not normally restart after its write, so the walk resumes on the new geometry.
    for (phase = 0; phase < PHASES; phase++) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        write_reg(REG_RING_SIZE, 9'($urandom_range(12, 1)));
        write_reg(REG_RING_COUNT, 9'($urandom_range(6, 1)));
      end else if (pick < 8) begin
        write_reg(REG_RING_SIZE, 9'($urandom_range(511)));
        write_reg(REG_RING_COUNT, 9'($urandom_range(511)));
      end else if ($urandom_range(1) == 0) begin
        write_reg(REG_RING_SIZE, 9'($urandom_range(4, 1)));
      end else begin
        write_reg(REG_RING_COUNT, 9'($urandom_range(3, 1)));
      end

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase

      // In one phase the receiver holds off for a long stretch while the sender keeps
      // offering, so that the block backs up and has to refuse requests.
      if (phase == 4) hold_req = 1'b1;

      repeat (ITEMS_PER_PHASE) send_request($urandom_range(99) < 3);
    end

    // Drain: let the last request be noted, wait for every owed index, then keep watching
    // in case anything extra appears.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
